>>> rtl/ldbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldbc_pkg
// Shared constants and types for the LED display buffer controller: operation
// codes, driver command bytes, field widths and the controller command bundle.
// ----------------------------------------------------------------------------
package ldbc_pkg;

    // Store geometry
    localparam int STORE_BYTES = 16;
    localparam int ADDR_W      = 4;
    localparam int BYTE_W      = 8;
    localparam int LEVEL_W     = 4;
    localparam int OP_W        = 3;
    localparam int IDX_W       = 5;

    // Input tdata layout, lowest bit first
    localparam int SD_W = ADDR_W + 2 * BYTE_W + LEVEL_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_UPDATE  = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd1;
    localparam logic [OP_W-1:0] OP_REFRESH = 3'd2;
    localparam logic [OP_W-1:0] OP_BRIGHT  = 3'd3;
    localparam logic [OP_W-1:0] OP_INIT    = 3'd4;

    // Driver command bytes
    localparam logic [BYTE_W-1:0] CMD_MODE     = 8'h40;
    localparam logic [BYTE_W-1:0] CMD_DISPLAY  = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_ADDRESS  = 8'hC0;
    localparam logic [BYTE_W-1:0] DISPLAY_ON   = 8'h08;
    localparam logic [BYTE_W-1:0] INIT_CONTROL = 8'h8F;

    // Emit index of the final byte of each emitting operation
    localparam logic [IDX_W-1:0] REFRESH_LAST_IDX = IDX_W'(STORE_BYTES);
    localparam logic [IDX_W-1:0] BRIGHT_LAST_IDX  = 5'd0;
    localparam logic [IDX_W-1:0] INIT_LAST_IDX    = 5'd1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              upd_en;   // masked store write from the input item
        logic              clr_en;   // zero the whole store
        logic              capture;  // latch the brightness level
        logic              emit;     // load the output register
        logic              emit_last;
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
    } cmd_t;

endpackage

>>> rtl/ldbc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldbc_ctrl
// Controller state machine: accepts one item, steps the emit index through
// the bytes of the operation and tells the datapath what to do each cycle.
// ----------------------------------------------------------------------------
module ldbc_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ldbc_pkg::OP_W-1:0]  s_op,
    input  logic                       out_free,
    output ldbc_pkg::cmd_t             cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                        state_reg, state_next;
    logic [ldbc_pkg::OP_W-1:0]   op_reg, op_next;
    logic [ldbc_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic                        accept;
    logic                        is_last;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Final byte of the running operation
    always_comb begin
        case (op_reg)
            ldbc_pkg::OP_REFRESH: is_last = (idx_reg == ldbc_pkg::REFRESH_LAST_IDX);
            ldbc_pkg::OP_BRIGHT:  is_last = (idx_reg == ldbc_pkg::BRIGHT_LAST_IDX);
            ldbc_pkg::OP_INIT:    is_last = (idx_reg == ldbc_pkg::INIT_LAST_IDX);
            default:              is_last = 1'b1;
        endcase
    end

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        cmd           = '0;
        cmd.op        = op_reg;
        cmd.idx       = idx_reg;
        cmd.emit_last = is_last;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    cmd.upd_en  = (s_op == ldbc_pkg::OP_UPDATE);
                    cmd.clr_en  = (s_op == ldbc_pkg::OP_CLEAR);
                    if (s_op inside {ldbc_pkg::OP_REFRESH, ldbc_pkg::OP_BRIGHT,
                                     ldbc_pkg::OP_INIT}) begin
                        state_next = ST_EMIT;
                        op_next    = s_op;
                        idx_next   = '0;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit = 1'b1;
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= ldbc_pkg::OP_UPDATE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

>>> rtl/ldbc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldbc_datapath
// Display store, wiring register, byte selection and the output register
// that holds one byte until the downstream side takes it.
// ----------------------------------------------------------------------------
module ldbc_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic [ldbc_pkg::SD_W-1:0]     s_tdata,
    input  ldbc_pkg::cmd_t                cmd,
    output logic                          out_free,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ldbc_pkg::BYTE_W-1:0]   m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    logic [ldbc_pkg::BYTE_W-1:0]  store_reg  [ldbc_pkg::STORE_BYTES];
    logic [ldbc_pkg::BYTE_W-1:0]  store_next [ldbc_pkg::STORE_BYTES];
    logic                         anode_reg;
    logic [ldbc_pkg::LEVEL_W-1:0] level_reg;
    logic                         valid_reg, valid_next;
    logic [ldbc_pkg::BYTE_W-1:0]  byte_reg;
    logic                         fend_reg;
    logic                         last_reg;

    logic [ldbc_pkg::ADDR_W-1:0]  in_addr;
    logic [ldbc_pkg::BYTE_W-1:0]  in_value;
    logic [ldbc_pkg::BYTE_W-1:0]  in_mask;
    logic [ldbc_pkg::LEVEL_W-1:0] in_level;
    logic [ldbc_pkg::LEVEL_W-1:0] level_m1;
    logic [ldbc_pkg::IDX_W-1:0]   idx_m1;
    logic [ldbc_pkg::ADDR_W-1:0]  rd_addr;
    logic [ldbc_pkg::BYTE_W-1:0]  sel_byte;
    logic                         sel_fend;

    // Unpack the input item
    assign in_addr  = s_tdata[ldbc_pkg::ADDR_W-1:0];
    assign in_value = s_tdata[ldbc_pkg::ADDR_W +: ldbc_pkg::BYTE_W];
    assign in_mask  = s_tdata[ldbc_pkg::ADDR_W + ldbc_pkg::BYTE_W +: ldbc_pkg::BYTE_W];
    assign in_level = s_tdata[ldbc_pkg::ADDR_W + 2 * ldbc_pkg::BYTE_W +: ldbc_pkg::LEVEL_W];

    // Store update: masked byte write, transposed bit write or clear
    always_comb begin
        for (int j = 0; j < ldbc_pkg::STORE_BYTES; j++) begin
            store_next[j] = store_reg[j];
            if (cmd.clr_en) begin
                store_next[j] = '0;
            end else if (cmd.upd_en) begin
                if (!anode_reg) begin
                    if (in_addr == ldbc_pkg::ADDR_W'(j)) begin
                        store_next[j] = (store_reg[j] & ~in_mask) | (in_value & in_mask);
                    end
                end else if ((j % 2) == int'(in_addr[ldbc_pkg::ADDR_W-1])
                             && in_mask[j / 2]) begin
                    store_next[j][in_addr[2:0]] = in_value[j / 2];
                end
            end
        end
    end

    // Byte for the current emit step
    assign idx_m1   = cmd.idx - 1'b1;
    assign rd_addr  = idx_m1[ldbc_pkg::ADDR_W-1:0];
    assign level_m1 = level_reg - 1'b1;

    always_comb begin
        sel_fend = 1'b1;
        case (cmd.op)
            ldbc_pkg::OP_REFRESH: begin
                sel_byte = (cmd.idx == '0) ? ldbc_pkg::CMD_ADDRESS : store_reg[rd_addr];
                sel_fend = cmd.emit_last;
            end
            ldbc_pkg::OP_BRIGHT: begin
                if (level_reg == '0) begin
                    sel_byte = ldbc_pkg::CMD_DISPLAY;
                end else begin
                    sel_byte = ldbc_pkg::CMD_DISPLAY | ldbc_pkg::DISPLAY_ON
                             | {5'd0, level_m1[2:0]};
                end
            end
            ldbc_pkg::OP_INIT: begin
                sel_byte = (cmd.idx == '0) ? ldbc_pkg::CMD_MODE : ldbc_pkg::INIT_CONTROL;
            end
            default: begin
                sel_byte = '0;
            end
        endcase
    end

    // Output register is free when empty or being taken
    assign out_free   = !valid_reg || m_tready;
    assign valid_next = cmd.emit ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            anode_reg <= 1'b0;
            for (int j = 0; j < ldbc_pkg::STORE_BYTES; j++) begin
                store_reg[j] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            if (cfg_we) begin
                anode_reg <= cfg_wdata;
            end
            for (int j = 0; j < ldbc_pkg::STORE_BYTES; j++) begin
                store_reg[j] <= store_next[j];
            end
        end
    end

    // Hold payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            level_reg <= in_level;
        end
        if (cmd.emit) begin
            byte_reg <= sel_byte;
            fend_reg <= sel_fend;
            last_reg <= cmd.emit_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = fend_reg;
    assign m_tlast  = last_reg;

endmodule

>>> rtl/led_display_buffer_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_display_buffer_controller_unit
// Host-side controller for a 16-byte LED driver display RAM: keeps the store
// and turns host operations into command and data bytes for the driver chip.
// ----------------------------------------------------------------------------
// The block takes one operation at a time. Update and clear finish in the
// accept cycle and the next item can be taken in the cycle after. Refresh
// emits the address command and the 16 store bytes, one byte per cycle
// unless the downstream side stalls, through a single output register;
// brightness emits one byte and init two. Downstream stalls hold the block.
// The input side is free again as soon as the final byte is loaded, while that
// byte still waits to be taken. The store resets to zero.
module led_display_buffer_controller_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration: anode_wiring
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,
    // Input items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [ldbc_pkg::SD_W-1:0]   s_tdata,  // address, value, bit_mask, level
    input  logic [ldbc_pkg::OP_W-1:0]   s_tuser,  // operation
    // Result items
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ldbc_pkg::BYTE_W-1:0] m_tdata,  // out_byte
    output logic                        m_tuser,  // frame_end
    output logic                        m_tlast   // last
);

    ldbc_pkg::cmd_t cmd;
    logic           out_free;

    ldbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .out_free (out_free),
        .cmd      (cmd)
    );

    ldbc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
